FILE: sv/salru_pkg.sv
// Package for the set-associative LRU tag store.
// Holds the default parameters, the register reset value, state and outcome codes.
// No dependencies.
package salru_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_SET_BITS   = 4;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_TAG_BITS   = 32;
  localparam int DEF_STAMP_BITS = 31;

  // Fixed field widths of the ports.
  localparam int CFG_W     = 3;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;

  localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 3'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // Access outcome codes.
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // Status flags gathered by the way scan.
  typedef struct packed {
    logic found;
    logic have_free;
  } scan_flags_t;

endpackage

FILE: sv/set_assoc_lru_cache_tags.sv
// Top level of the set-associative tag store with LRU replacement.
// Holds the set memory, valid bits, counters and sequencer; uses salru_scan.
// Depends on salru_pkg.
//
//   channel  | handshake                 | word
//   ---------+---------------------------+-----------------------------------
//   access   | start, busy               | set_sel, tag, timestamp
//   result   | done (one-cycle strobe)   | outcome, way_used, *_total
//   config   | cfg_valid, cfg_ready      | cfg_data (ways_in_use)
//
// The result strobe follows the scan over the effective ways_in_use (the
// configured count clamped to 1..WAYS) and the write-back into the set memory.
// busy drops in the cycle that shows the result, so the next access can be
// taken in that cycle. Reset clears valid bits, counters and the register; the
// memory contents are left alone. The result side has no stall.
module set_assoc_lru_cache_tags
  import salru_pkg::*;
#(
  parameter int SET_BITS   = DEF_SET_BITS,
  parameter int WAYS       = DEF_WAYS,
  parameter int TAG_BITS   = DEF_TAG_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [SET_BITS-1:0]   set_sel,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic [STAMP_BITS-1:0] timestamp,
  output logic                  done,
  output logic [1:0]            outcome,
  output logic [WAY_OUT_W-1:0]  way_used,
  output logic [CNT_W-1:0]      hits_total,
  output logic [CNT_W-1:0]      misses_total,
  output logic [CNT_W-1:0]      evictions_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W   = $clog2(WAYS + 1);
  localparam int CMP_W    = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
  localparam int ENT_W    = TAG_BITS + STAMP_BITS;

  // Set memory: one row per set, each way holds {tag, stamp}.
  logic [WAYS-1:0][ENT_W-1:0] mem [NUM_SETS];
  logic [WAYS-1:0]            valid_bits [NUM_SETS];

  state_t                     state;
  state_t                     state_next;
  logic [CFG_W-1:0]           ways_in_use;
  logic [WAYS-1:0][ENT_W-1:0] rd_row;
  logic [WAYS-1:0]            rd_valid;
  logic [SET_BITS-1:0]        acc_set;
  logic [TAG_BITS-1:0]        acc_tag;
  logic [STAMP_BITS-1:0]      acc_stamp;
  logic [WAY_W-1:0]           acc_last;
  logic [WAY_W-1:0]           way_idx;
  logic [CNT_W-1:0]           hit_ctr;
  logic [CNT_W-1:0]           miss_ctr;
  logic [CNT_W-1:0]           evict_count;
  outcome_t                   outcome_q;

  logic                       accept;
  logic                       scan_step;
  logic                       mem_we;
  logic [CMP_W-1:0]           cfg_ext;
  logic [WAY_W-1:0]           last_way;
  logic [ENT_W-1:0]           cur_ent;
  scan_flags_t                flags;
  logic [WAY_W-1:0]           hit_way;
  logic [WAY_W-1:0]           free_way;
  logic [WAY_W-1:0]           lru_way;
  logic [WAY_W-1:0]           sel_way;
  outcome_t                   sel_outcome;
  logic [WAYS-1:0][ENT_W-1:0] new_row;
  logic [WAY_W+1:0]           way_ext;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Clamp the configured way count to 1..WAYS and keep the last way index.
  assign cfg_ext = CMP_W'(ways_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      last_way = '0;
    end else if (cfg_ext > CMP_W'(WAYS)) begin
      last_way = WAY_W'(WAYS - 1);
    end else begin
      last_way = WAY_W'(cfg_ext - CMP_W'(1));
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= WAYS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ways_in_use <= cfg_data;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes of the sequencer.
  always_comb begin
    state_next = state;
    scan_step  = 1'b0;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        if (way_idx == acc_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the access word and read the set row on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row    <= mem[set_sel];
      rd_valid  <= valid_bits[set_sel];
      acc_set   <= set_sel;
      acc_tag   <= tag;
      acc_stamp <= timestamp;
      acc_last  <= last_way;
    end
  end

  // Way counter for the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      way_idx <= '0;
    end else if (accept) begin
      way_idx <= '0;
    end else if (scan_step) begin
      way_idx <= way_idx + WAY_W'(1);
    end
  end

  assign cur_ent = rd_row[way_idx];

  salru_scan #(
    .WAYS       (WAYS),
    .TAG_BITS   (TAG_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (scan_step),
    .first     (way_idx == '0),
    .way       (way_idx),
    .ent_valid (rd_valid[way_idx]),
    .ent_tag   (cur_ent[ENT_W-1:STAMP_BITS]),
    .ent_stamp (cur_ent[STAMP_BITS-1:0]),
    .req_tag   (acc_tag),
    .flags     (flags),
    .hit_way   (hit_way),
    .free_way  (free_way),
    .lru_way   (lru_way)
  );

  // Pick the way and outcome from the scan, and build the updated row.
  always_comb begin
    if (flags.found) begin
      sel_way     = hit_way;
      sel_outcome = OUT_HIT;
    end else if (flags.have_free) begin
      sel_way     = free_way;
      sel_outcome = OUT_FILL;
    end else begin
      sel_way     = lru_way;
      sel_outcome = OUT_EVICT;
    end
    new_row          = rd_row;
    new_row[sel_way] = {acc_tag, acc_stamp};
  end

  assign way_ext = {2'b00, sel_way};

  // Write the row back into the set memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[acc_set] <= new_row;
    end
  end

  // Valid bits are flops so that reset clears every line at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_bits[s] <= '0;
      end
    end else if (mem_we) begin
      valid_bits[acc_set][sel_way] <= 1'b1;
    end
  end

  // Saturating counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_ctr     <= '0;
      miss_ctr    <= '0;
      evict_count <= '0;
    end else if (mem_we) begin
      if (sel_outcome == OUT_HIT) begin
        if (hit_ctr != '1) begin
          hit_ctr <= hit_ctr + CNT_W'(1);
        end
      end else begin
        if (miss_ctr != '1) begin
          miss_ctr <= miss_ctr + CNT_W'(1);
        end
        if (sel_outcome == OUT_EVICT && evict_count != '1) begin
          evict_count <= evict_count + CNT_W'(1);
        end
      end
    end
  end

  // Result strobe and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      outcome_q <= sel_outcome;
      way_used  <= way_ext[WAY_OUT_W-1:0];
    end
  end

  assign outcome         = outcome_q;
  assign hits_total      = hit_ctr;
  assign misses_total    = miss_ctr;
  assign evictions_total = evict_count;

endmodule

FILE: sv/salru_scan.sv
// Way scan unit: looks at one way of the selected set per cycle.
// Tracks the first hit, the first invalid way and the oldest stamp.
// Depends on salru_pkg.
module salru_scan
  import salru_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int TAG_BITS   = DEF_TAG_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS,
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  first,
  input  logic [WAY_W-1:0]      way,
  input  logic                  ent_valid,
  input  logic [TAG_BITS-1:0]   ent_tag,
  input  logic [STAMP_BITS-1:0] ent_stamp,
  input  logic [TAG_BITS-1:0]   req_tag,
  output scan_flags_t           flags,
  output logic [WAY_W-1:0]      hit_way,
  output logic [WAY_W-1:0]      free_way,
  output logic [WAY_W-1:0]      lru_way
);

  logic [STAMP_BITS-1:0] best_stamp;
  logic                  hit_now;

  // A way hits when it holds a valid line with the requested tag.
  assign hit_now = ent_valid && (ent_tag == req_tag);

  // Flags restart on the first way of each access.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (step) begin
      if (first) begin
        flags.found     <= hit_now;
        flags.have_free <= !ent_valid;
      end else begin
        if (hit_now) begin
          flags.found <= 1'b1;
        end
        if (!ent_valid) begin
          flags.have_free <= 1'b1;
        end
      end
    end
  end

  // Way numbers and the running minimum; lower ways win ties.
  always_ff @(posedge clk) begin
    if (step) begin
      if (first) begin
        hit_way    <= way;
        free_way   <= way;
        lru_way    <= way;
        best_stamp <= ent_stamp;
      end else begin
        if (hit_now && !flags.found) begin
          hit_way <= way;
        end
        if (!ent_valid && !flags.have_free) begin
          free_way <= way;
        end
        if (ent_stamp < best_stamp) begin
          best_stamp <= ent_stamp;
          lru_way    <= way;
        end
      end
    end
  end

endmodule
